### sv/fep_pkg.sv
// ----------------------------------------------------------------------------
// fep_pkg
// Shared widths, angle constants and rounding helpers for the Frenet error
// projection pipeline.
// ----------------------------------------------------------------------------
package fep_pkg;

    localparam int F      = 18;
    localparam int W      = 32;
    localparam int HW     = 21;
    localparam int NUM_IN = 9;

    localparam int IN_TDATA_W  = ((NUM_IN * W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((W + HW + 7) / 8) * 8;

    localparam int DW    = W + 1;
    localparam int PW    = 2 * DW;
    localparam int SW    = PW + 1;
    localparam int RW    = SW - 1;
    localparam int AW    = W + 4;
    localparam int TW    = F + 1;
    localparam int QW    = F + 1;
    localparam int CW    = 34;
    localparam int CSH   = 30 - F;
    localparam int SCW   = F + 2;
    localparam int DXW   = DW + 1;
    localparam int RND_W = 72;

    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = PI_Q30 / 2;
    localparam longint GAIN_Q30    = 64'sd652032874;
    localparam int     CORDIC_N    = 30;
    localparam longint PI_Q        = (PI_Q30 + (longint'(1) << (29 - F))) >> (30 - F);
    localparam longint TWO_PI_Q    = 2 * PI_Q;
    localparam longint LEN2_EPS    = (longint'(1) << (2 * F)) / 64'sd1000000000000;

    function automatic longint cordic_atan(input int i);
        case (i)
            0: return 64'sd843314857;
            1: return 64'sd497837829;
            2: return 64'sd263043837;
            3: return 64'sd133525159;
            4: return 64'sd67021687;
            5: return 64'sd33543516;
            6: return 64'sd16775851;
            7: return 64'sd8388437;
            8: return 64'sd4194283;
            9: return 64'sd2097149;
            default: return longint'(1) << (30 - i);
        endcase
    endfunction

    // divide by 2^F, half away from zero
    function automatic logic signed [RND_W-1:0] round_f(input logic signed [RND_W-1:0] v);
        logic [RND_W-1:0] m;
        logic [RND_W-1:0] r;
        m = v[RND_W-1] ? -v : v;
        r = (m + (RND_W'(1) << (F - 1))) >> F;
        return v[RND_W-1] ? -$signed(r) : $signed(r);
    endfunction

endpackage

### sv/fep_wrap.sv
// ----------------------------------------------------------------------------
// fep_wrap
// Three-stage angle wrap into [-pi, pi] by reciprocal multiply and one
// remainder correction, with a side payload carried alongside.
// ----------------------------------------------------------------------------
module fep_wrap #(
    parameter int SIDE_W = 1
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic signed [fep_pkg::AW-1:0]    in_angle,
    input  logic        [SIDE_W-1:0]         in_side,
    output logic                             out_valid,
    output logic signed [fep_pkg::HW-1:0]    out_angle,
    output logic        [SIDE_W-1:0]         out_side
);
    import fep_pkg::*;

    localparam int     S     = AW + 1;
    localparam longint RECIP = (longint'(1) << S) / TWO_PI_Q;
    localparam int     MW    = $clog2(RECIP + 1);
    localparam int     QDW   = AW + MW - S;

    localparam logic        [MW-1:0] RECIP_V = MW'(RECIP);
    localparam logic        [AW-1:0] D_V     = AW'(TWO_PI_Q);
    localparam logic signed [AW-1:0] PI_M1   = AW'(PI_Q - 1);
    localparam logic signed [AW-1:0] NEG_PI  = AW'(-PI_Q);

    logic              v1_reg, v2_reg, v3_reg;
    logic [AW+MW-1:0]  prod_reg;
    logic [AW-1:0]     n_reg, rem_reg;
    logic              gt1_reg, gt2_reg;
    logic [SIDE_W-1:0] side1_reg, side2_reg, side3_reg;
    logic signed [HW-1:0] ang_reg;

    logic              gt;
    logic [AW-1:0]     n;
    logic [QDW-1:0]    q0;
    logic [AW-1:0]     qd;
    logic [AW-1:0]     r;
    logic signed [AW-1:0] res;

    always_comb begin
        gt = in_angle > NEG_PI;
        n  = gt ? AW'(in_angle + PI_M1) : AW'(PI_M1 - in_angle);
        q0 = prod_reg[AW+MW-1:S];
        qd = AW'(q0 * D_V);
        r  = (rem_reg >= D_V) ? rem_reg - D_V : rem_reg;
        res = gt2_reg ? $signed(r) - PI_M1 : PI_M1 - $signed(r);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg  <= n * RECIP_V;
            n_reg     <= n;
            gt1_reg   <= gt;
            side1_reg <= in_side;
            rem_reg   <= n_reg - qd;
            gt2_reg   <= gt1_reg;
            side2_reg <= side1_reg;
            ang_reg   <= HW'(res);
            side3_reg <= side2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_angle = ang_reg;
    assign out_side  = side3_reg;

endmodule

### sv/fep_div.sv
// ----------------------------------------------------------------------------
// fep_div
// Pipelined restoring divider, one quotient bit per stage, producing the
// projection quotient to F+1 bits.
// ----------------------------------------------------------------------------
module fep_div #(
    parameter int SIDE_W = 1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [fep_pkg::RW-1:0]     in_num,
    input  logic [fep_pkg::RW-1:0]     in_den,
    input  logic [SIDE_W-1:0]          in_side,
    output logic                       out_valid,
    output logic [fep_pkg::QW-1:0]     out_quot,
    output logic [SIDE_W-1:0]          out_side
);
    import fep_pkg::*;

    logic              v_reg    [QW];
    logic [RW-1:0]     r_reg    [QW];
    logic [RW-1:0]     d_reg    [QW];
    logic [QW-1:0]     q_reg    [QW];
    logic [SIDE_W-1:0] side_reg [QW];

    logic              v_in    [QW];
    logic [RW-1:0]     r_in    [QW];
    logic [RW-1:0]     d_in    [QW];
    logic [QW-1:0]     q_in    [QW];
    logic [SIDE_W-1:0] side_in [QW];
    logic [RW-1:0]     r_next  [QW];
    logic [QW-1:0]     q_next  [QW];
    logic [RW:0]       rs      [QW];

    always_comb begin
        for (int k = 0; k < QW; k++) begin
            if (k == 0) begin
                v_in[k]    = in_valid;
                r_in[k]    = in_num;
                d_in[k]    = in_den;
                q_in[k]    = '0;
                side_in[k] = in_side;
            end else begin
                v_in[k]    = v_reg[k-1];
                r_in[k]    = r_reg[k-1];
                d_in[k]    = d_reg[k-1];
                q_in[k]    = q_reg[k-1];
                side_in[k] = side_reg[k-1];
            end
            rs[k] = {r_in[k], 1'b0};
            if (rs[k] >= {1'b0, d_in[k]}) begin
                r_next[k] = RW'(rs[k] - {1'b0, d_in[k]});
                q_next[k] = {q_in[k][QW-2:0], 1'b1};
            end else begin
                r_next[k] = rs[k][RW-1:0];
                q_next[k] = {q_in[k][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < QW; k++) v_reg[k] <= 1'b0;
        end else if (en) begin
            for (int k = 0; k < QW; k++) v_reg[k] <= v_in[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < QW; k++) begin
                r_reg[k]    <= r_next[k];
                d_reg[k]    <= d_in[k];
                q_reg[k]    <= q_next[k];
                side_reg[k] <= side_in[k];
            end
        end
    end

    assign out_valid = v_reg[QW-1];
    assign out_quot  = q_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule

### sv/fep_cordic.sv
// ----------------------------------------------------------------------------
// fep_cordic
// Pipelined rotation-mode CORDIC at Q30: quadrant fold, one micro-rotation
// per stage, then flip and rounding to Q(F) sin and cos.
// ----------------------------------------------------------------------------
module fep_cordic #(
    parameter int SIDE_W = 1
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic signed [fep_pkg::HW-1:0]   in_angle,
    input  logic        [SIDE_W-1:0]        in_side,
    output logic                            out_valid,
    output logic signed [fep_pkg::SCW-1:0]  out_sin,
    output logic signed [fep_pkg::SCW-1:0]  out_cos,
    output logic        [SIDE_W-1:0]        out_side
);
    import fep_pkg::*;

    localparam logic signed [CW-1:0] HALF_V = CW'(HALF_PI_Q30);
    localparam logic signed [CW-1:0] PI_V   = CW'(PI_Q30);
    localparam logic signed [CW-1:0] GAIN_V = CW'(GAIN_Q30);

    function automatic logic signed [CW-1:0] rnd_c(input logic signed [CW-1:0] v);
        logic [CW-1:0] m;
        logic [CW-1:0] r;
        m = v[CW-1] ? -v : v;
        r = (m + (CW'(1) << (CSH - 1))) >> CSH;
        return v[CW-1] ? -$signed(r) : $signed(r);
    endfunction

    logic                 vf_reg, flipf_reg;
    logic signed [CW-1:0] zf_reg;
    logic [SIDE_W-1:0]    sidef_reg;

    logic                 v_reg    [CORDIC_N];
    logic                 flip_reg [CORDIC_N];
    logic signed [CW-1:0] x_reg    [CORDIC_N];
    logic signed [CW-1:0] y_reg    [CORDIC_N];
    logic signed [CW-1:0] z_reg    [CORDIC_N];
    logic [SIDE_W-1:0]    side_reg [CORDIC_N];

    logic                 vo_reg;
    logic signed [SCW-1:0] sin_reg, cos_reg;
    logic [SIDE_W-1:0]    sideo_reg;

    logic signed [CW-1:0] zin, zfold;
    logic                 fold;
    logic                 v_in    [CORDIC_N];
    logic                 flip_in [CORDIC_N];
    logic signed [CW-1:0] x_in    [CORDIC_N];
    logic signed [CW-1:0] y_in    [CORDIC_N];
    logic signed [CW-1:0] z_in    [CORDIC_N];
    logic [SIDE_W-1:0]    side_in [CORDIC_N];
    logic signed [CW-1:0] x_next  [CORDIC_N];
    logic signed [CW-1:0] y_next  [CORDIC_N];
    logic signed [CW-1:0] z_next  [CORDIC_N];
    logic signed [CW-1:0] xf, yf;

    always_comb begin
        zin = CW'(in_angle) <<< CSH;
        if (zin > HALF_V) begin
            zfold = zin - PI_V;
            fold  = 1'b1;
        end else if (zin < -HALF_V) begin
            zfold = zin + PI_V;
            fold  = 1'b1;
        end else begin
            zfold = zin;
            fold  = 1'b0;
        end
    end

    always_comb begin
        for (int k = 0; k < CORDIC_N; k++) begin
            if (k == 0) begin
                v_in[k]    = vf_reg;
                flip_in[k] = flipf_reg;
                x_in[k]    = GAIN_V;
                y_in[k]    = '0;
                z_in[k]    = zf_reg;
                side_in[k] = sidef_reg;
            end else begin
                v_in[k]    = v_reg[k-1];
                flip_in[k] = flip_reg[k-1];
                x_in[k]    = x_reg[k-1];
                y_in[k]    = y_reg[k-1];
                z_in[k]    = z_reg[k-1];
                side_in[k] = side_reg[k-1];
            end
            if (!z_in[k][CW-1]) begin
                x_next[k] = x_in[k] - (y_in[k] >>> k);
                y_next[k] = y_in[k] + (x_in[k] >>> k);
                z_next[k] = z_in[k] - CW'(cordic_atan(k));
            end else begin
                x_next[k] = x_in[k] + (y_in[k] >>> k);
                y_next[k] = y_in[k] - (x_in[k] >>> k);
                z_next[k] = z_in[k] + CW'(cordic_atan(k));
            end
        end
        xf = flip_reg[CORDIC_N-1] ? -x_reg[CORDIC_N-1] : x_reg[CORDIC_N-1];
        yf = flip_reg[CORDIC_N-1] ? -y_reg[CORDIC_N-1] : y_reg[CORDIC_N-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vf_reg <= 1'b0;
            vo_reg <= 1'b0;
            for (int k = 0; k < CORDIC_N; k++) v_reg[k] <= 1'b0;
        end else if (en) begin
            vf_reg <= in_valid;
            vo_reg <= v_reg[CORDIC_N-1];
            for (int k = 0; k < CORDIC_N; k++) v_reg[k] <= v_in[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            zf_reg    <= zfold;
            flipf_reg <= fold;
            sidef_reg <= in_side;
            for (int k = 0; k < CORDIC_N; k++) begin
                flip_reg[k] <= flip_in[k];
                x_reg[k]    <= x_next[k];
                y_reg[k]    <= y_next[k];
                z_reg[k]    <= z_next[k];
                side_reg[k] <= side_in[k];
            end
            sin_reg   <= SCW'(rnd_c(yf));
            cos_reg   <= SCW'(rnd_c(xf));
            sideo_reg <= side_reg[CORDIC_N-1];
        end
    end

    assign out_valid = vo_reg;
    assign out_sin   = sin_reg;
    assign out_cos   = cos_reg;
    assign out_side  = sideo_reg;

endmodule

### sv/frenet_error_projection_unit.sv
// ----------------------------------------------------------------------------
// frenet_error_projection_unit
// Projects a pose onto a reference segment and returns the lateral and the
// wrapped heading error in signed Q18.
// Throughput: one beat per cycle; the divider, the three angle wraps and the
// CORDIC are fully pipelined, so s_tready only drops while a result waits.
// Reset: aresetn clears every stage valid bit; data registers are not reset.
// ----------------------------------------------------------------------------
module frenet_error_projection_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // pose_x, pose_y, pose_heading, seg_start_x, seg_start_y, seg_end_x,
    // seg_end_y, seg_start_heading, seg_end_heading
    input  logic [fep_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // lateral_error, heading_error, zero pad
    output logic [fep_pkg::OUT_TDATA_W-1:0]    m_tdata
);
    import fep_pkg::*;

    localparam int PX = 0, PY = 1, TH = 2, AX = 3, AY = 4;
    localparam int BX = 5, BY = 6, H0 = 7, H1 = 8;
    localparam int MPW = TW + 1 + DW;
    localparam int MHW = TW + 1 + HW;

    localparam logic signed [SW-1:0]    EPS_V  = SW'(LEN2_EPS);
    localparam logic signed [RND_W-1:0] SAT_HI = RND_W'((longint'(1) << (W - 1)) - 1);
    localparam logic signed [RND_W-1:0] SAT_LO = -SAT_HI - 1;
    localparam logic signed [HW-1:0]    PI_HW  = HW'(PI_Q);

    typedef struct packed {
        logic signed [DW-1:0] abx;
        logic signed [DW-1:0] aby;
        logic signed [DW-1:0] apx;
        logic signed [DW-1:0] apy;
        logic signed [W-1:0]  h0;
        logic signed [W-1:0]  th;
    } geo_t;

    typedef struct packed {
        logic signed [PW-1:0] pdx;
        logic signed [PW-1:0] pdy;
        logic signed [PW-1:0] pxx;
        logic signed [PW-1:0] pyy;
        geo_t                 g;
        logic signed [HW-1:0] wdh;
    } p1_t;

    typedef struct packed {
        logic signed [SW-1:0] dot;
        logic signed [SW-1:0] len2;
        geo_t                 g;
        logic signed [HW-1:0] wdh;
    } p2_t;

    typedef struct packed {
        geo_t                 g;
        logic signed [HW-1:0] wdh;
        logic                 zero;
        logic                 full;
    } dv_t;

    typedef struct packed {
        logic [TW-1:0]        t;
        geo_t                 g;
        logic signed [HW-1:0] wdh;
    } m0_t;

    typedef struct packed {
        logic signed [MPW-1:0] ptx;
        logic signed [MPW-1:0] pty;
        logic signed [MHW-1:0] pth;
        logic signed [DW-1:0]  apx;
        logic signed [DW-1:0]  apy;
        logic signed [W-1:0]   h0;
        logic signed [W-1:0]   th;
    } m1_t;

    typedef struct packed {
        logic signed [DXW-1:0] dx;
        logic signed [DXW-1:0] dy;
        logic signed [W:0]     wpsi;
        logic signed [W+1:0]   eraw;
    } m2_t;

    typedef struct packed {
        logic signed [DXW-1:0] dx;
        logic signed [DXW-1:0] dy;
        logic signed [W+1:0]   eraw;
    } w2s_t;

    typedef struct packed {
        logic signed [DXW-1:0] dx;
        logic signed [DXW-1:0] dy;
        logic signed [HW-1:0]  psi;
    } w3s_t;

    typedef struct packed {
        logic signed [DXW-1:0] dx;
        logic signed [DXW-1:0] dy;
        logic signed [HW-1:0]  ep;
    } cs_t;

    typedef struct packed {
        logic signed [SCW+DXW-1:0] pa;
        logic signed [SCW+DXW-1:0] pb;
        logic signed [HW-1:0]      ep;
    } e1_t;

    logic en;

    logic                v0_reg;
    logic signed [W-1:0] in_reg [NUM_IN];
    geo_t                geo;
    logic signed [DW-1:0] dh;

    logic w1_valid;
    logic signed [HW-1:0] w1_angle;
    logic [$bits(geo_t)-1:0] w1_side;
    geo_t w1_g;

    logic v1_reg, v2_reg, vm0_reg, vm1_reg, vm2_reg, ve1_reg, m_tvalid_reg;
    p1_t  p1_reg, p1_next;
    p2_t  p2_reg, p2_next;
    dv_t  dv_in, dv_out;
    m0_t  m0_reg, m0_next;
    m1_t  m1_reg, m1_next;
    m2_t  m2_reg, m2_next;
    e1_t  e1_reg, e1_next;

    logic div_valid;
    logic [QW-1:0] div_quot;
    logic [$bits(dv_t)-1:0] div_side;
    logic [QW:0] qp;

    logic signed [RND_W-1:0] rtx, rty, rth, wps, er, sum, ey;

    logic w2_valid, w3_valid, cd_valid;
    logic signed [HW-1:0] w2_angle, w3_angle;
    logic [$bits(w2s_t)-1:0] w2_side;
    logic [$bits(w3s_t)-1:0] w3_side;
    logic [$bits(cs_t)-1:0]  cd_side;
    w2s_t w2s_in, w2s;
    w3s_t w3s_in, w3s;
    cs_t  css_in, css;
    logic signed [SCW-1:0] sn, cs;

    logic signed [W-1:0]  lat_reg, lat_next;
    logic signed [HW-1:0] hd_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - W - HW){1'b0}}, hd_reg, lat_reg};

    // input stage
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < NUM_IN; k++) in_reg[k] <= s_tdata[k*W +: W];
        end
    end

    always_comb begin
        geo.abx = DW'(in_reg[BX]) - DW'(in_reg[AX]);
        geo.aby = DW'(in_reg[BY]) - DW'(in_reg[AY]);
        geo.apx = DW'(in_reg[PX]) - DW'(in_reg[AX]);
        geo.apy = DW'(in_reg[PY]) - DW'(in_reg[AY]);
        geo.h0  = in_reg[H0];
        geo.th  = in_reg[TH];
        dh      = DW'(in_reg[H1]) - DW'(in_reg[H0]);
    end

    fep_wrap #(.SIDE_W($bits(geo_t))) u_wrap_dh (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v0_reg),
        .in_angle  (AW'(dh)),
        .in_side   (geo),
        .out_valid (w1_valid),
        .out_angle (w1_angle),
        .out_side  (w1_side)
    );

    // squares and dot products
    always_comb begin
        w1_g        = geo_t'(w1_side);
        p1_next.pdx = w1_g.apx * w1_g.abx;
        p1_next.pdy = w1_g.apy * w1_g.aby;
        p1_next.pxx = w1_g.abx * w1_g.abx;
        p1_next.pyy = w1_g.aby * w1_g.aby;
        p1_next.g   = w1_g;
        p1_next.wdh = w1_angle;

        p2_next.dot  = SW'(p1_reg.pdx) + SW'(p1_reg.pdy);
        p2_next.len2 = SW'(p1_reg.pxx) + SW'(p1_reg.pyy);
        p2_next.g    = p1_reg.g;
        p2_next.wdh  = p1_reg.wdh;

        dv_in.g    = p2_reg.g;
        dv_in.wdh  = p2_reg.wdh;
        dv_in.zero = !(p2_reg.len2 > EPS_V && p2_reg.dot > 0);
        dv_in.full = p2_reg.dot >= p2_reg.len2;
    end

    fep_div #(.SIDE_W($bits(dv_t))) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v2_reg),
        .in_num    (p2_reg.dot[RW-1:0]),
        .in_den    (p2_reg.len2[RW-1:0]),
        .in_side   (dv_in),
        .out_valid (div_valid),
        .out_quot  (div_quot),
        .out_side  (div_side)
    );

    // projection parameter, interpolation and offsets
    always_comb begin
        dv_out = dv_t'(div_side);
        qp     = {1'b0, div_quot} + 1'b1;
        if (dv_out.zero) begin
            m0_next.t = '0;
        end else if (dv_out.full) begin
            m0_next.t = TW'(1) << F;
        end else begin
            m0_next.t = qp[QW:1];
        end
        m0_next.g   = dv_out.g;
        m0_next.wdh = dv_out.wdh;

        m1_next.ptx = $signed({1'b0, m0_reg.t}) * m0_reg.g.abx;
        m1_next.pty = $signed({1'b0, m0_reg.t}) * m0_reg.g.aby;
        m1_next.pth = $signed({1'b0, m0_reg.t}) * m0_reg.wdh;
        m1_next.apx = m0_reg.g.apx;
        m1_next.apy = m0_reg.g.apy;
        m1_next.h0  = m0_reg.g.h0;
        m1_next.th  = m0_reg.g.th;

        rtx = round_f(RND_W'(m1_reg.ptx));
        rty = round_f(RND_W'(m1_reg.pty));
        rth = round_f(RND_W'(m1_reg.pth));
        wps = RND_W'(m1_reg.h0) + rth;
        er  = RND_W'(m1_reg.th) - wps;
        m2_next.dx   = DXW'(RND_W'(m1_reg.apx) - rtx);
        m2_next.dy   = DXW'(RND_W'(m1_reg.apy) - rty);
        m2_next.wpsi = (W + 1)'(wps);
        m2_next.eraw = (W + 2)'(er);

        w2s_in.dx   = m2_reg.dx;
        w2s_in.dy   = m2_reg.dy;
        w2s_in.eraw = m2_reg.eraw;
    end

    fep_wrap #(.SIDE_W($bits(w2s_t))) u_wrap_psi (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vm2_reg),
        .in_angle  (AW'(m2_reg.wpsi)),
        .in_side   (w2s_in),
        .out_valid (w2_valid),
        .out_angle (w2_angle),
        .out_side  (w2_side)
    );

    always_comb begin
        w2s        = w2s_t'(w2_side);
        w3s_in.dx  = w2s.dx;
        w3s_in.dy  = w2s.dy;
        w3s_in.psi = w2_angle;
    end

    fep_wrap #(.SIDE_W($bits(w3s_t))) u_wrap_err (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (w2_valid),
        .in_angle  (AW'(w2s.eraw)),
        .in_side   (w3s_in),
        .out_valid (w3_valid),
        .out_angle (w3_angle),
        .out_side  (w3_side)
    );

    always_comb begin
        w3s       = w3s_t'(w3_side);
        css_in.dx = w3s.dx;
        css_in.dy = w3s.dy;
        css_in.ep = w3_angle;
    end

    fep_cordic #(.SIDE_W($bits(cs_t))) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (w3_valid),
        .in_angle  (w3s.psi),
        .in_side   (css_in),
        .out_valid (cd_valid),
        .out_sin   (sn),
        .out_cos   (cs),
        .out_side  (cd_side)
    );

    // lateral rotation and saturation
    always_comb begin
        css        = cs_t'(cd_side);
        e1_next.pa = sn * css.dx;
        e1_next.pb = cs * css.dy;
        e1_next.ep = css.ep;

        sum = RND_W'(e1_reg.pb) - RND_W'(e1_reg.pa);
        ey  = round_f(sum);
        if (ey > SAT_HI) begin
            lat_next = W'(SAT_HI);
        end else if (ey < SAT_LO) begin
            lat_next = W'(SAT_LO);
        end else begin
            lat_next = W'(ey);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg       <= 1'b0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            vm0_reg      <= 1'b0;
            vm1_reg      <= 1'b0;
            vm2_reg      <= 1'b0;
            ve1_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            v0_reg       <= s_tvalid;
            v1_reg       <= w1_valid;
            v2_reg       <= v1_reg;
            vm0_reg      <= div_valid;
            vm1_reg      <= vm0_reg;
            vm2_reg      <= vm1_reg;
            ve1_reg      <= cd_valid;
            m_tvalid_reg <= ve1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg  <= p1_next;
            p2_reg  <= p2_next;
            m0_reg  <= m0_next;
            m1_reg  <= m1_next;
            m2_reg  <= m2_next;
            e1_reg  <= e1_next;
            lat_reg <= lat_next;
            hd_reg  <= e1_reg.ep;
        end
    end

    a_heading_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (hd_reg <= PI_HW && hd_reg >= -PI_HW))
        else $error("heading error outside wrap range");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> v0_reg)
        else $error("accepted beat not captured");

endmodule

### tb/sv/tb_frenet_error_projection_unit.sv
// ----------------------------------------------------------------------------
// tb_frenet_error_projection_unit
// Streams pose/segment beats into the projection unit, predicts lateral and
// heading error in Q18 fixed point, and compares every result beat in order.
// ----------------------------------------------------------------------------
module tb_frenet_error_projection_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import fep_pkg::*;

    typedef logic signed [31:0] word_t;
    typedef struct packed {
        logic signed [20:0] heading_error;
        logic signed [31:0] lateral_error;
    } err_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    logic [IN_TDATA_W-1:0] pending_beats[$];
    err_t expected_errs[$];
    int errors = 0;
    bit hold_rx = 1'b0;
    bit start_hold = 1'b0;
    bit calm = 1'b0;
    bit pause_tx = 1'b0;

    frenet_error_projection_unit dut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic signed [127:0] rnd_q(input logic signed [127:0] v);
        logic signed [127:0] m;
        m = v < 0 ? -v : v;
        m = (m + (128'sd1 <<< (F - 1))) >>> F;
        return v < 0 ? -m : m;
    endfunction

    function automatic longint rnd_n(input longint v, input int n);
        longint m;
        m = v < 0 ? -v : v;
        m = (m + (longint'(1) <<< (n - 1))) >>> n;
        return v < 0 ? -m : m;
    endfunction

    function automatic longint floor_sh(input longint v, input int n);
        return v >>> n;
    endfunction

    function automatic longint wrap(input longint a);
        longint k;
        if (a > PI_Q) begin
            k = (a - PI_Q - 1) / TWO_PI_Q + 1;
            return a - k * TWO_PI_Q;
        end
        if (a < -PI_Q) begin
            k = (-PI_Q - a - 1) / TWO_PI_Q + 1;
            return a + k * TWO_PI_Q;
        end
        return a;
    endfunction

    function automatic err_t project_pose(input logic [IN_TDATA_W-1:0] d);
        longint px, py, th, ax, ay, bx, by, h0, h1;
        longint abx, aby, apx, apy, t, dx, dy, wpsi, z, x, y, nx, at, sn, cs;
        logic signed [127:0] dot, len2, r, ey;
        logic [31:0] q;
        bit flip;
        err_t e;
        px = word_t'(d[31:0]);     py = word_t'(d[63:32]);   th = word_t'(d[95:64]);
        ax = word_t'(d[127:96]);   ay = word_t'(d[159:128]);
        bx = word_t'(d[191:160]);  by = word_t'(d[223:192]);
        h0 = word_t'(d[255:224]);  h1 = word_t'(d[287:256]);
        abx = bx - ax; aby = by - ay; apx = px - ax; apy = py - ay;
        dot = 128'(apx) * abx + 128'(apy) * aby;
        len2 = 128'(abx) * abx + 128'(aby) * aby;
        t = 0;
        if (len2 > LEN2_EPS && dot >= 1) begin
            if (dot >= len2) t = longint'(1) <<< F;
            else begin
                r = dot; q = 0;
                for (int i = 0; i <= F; i++) begin
                    r = r <<< 1; q = q << 1;
                    if (r >= len2) begin
                        r = r - len2; q[0] = 1'b1;
                    end
                end
                t = (longint'(q) + 1) >>> 1;
            end
        end
        dx = apx - longint'(rnd_q(128'(t) * abx));
        dy = apy - longint'(rnd_q(128'(t) * aby));
        wpsi = h0 + longint'(rnd_q(128'(t) * wrap(h1 - h0)));
        z = wrap(wpsi) * (longint'(1) <<< (30 - F));
        x = GAIN_Q30; y = 0; flip = 1'b0;
        if (z > PI_Q30 / 2) begin
            z -= PI_Q30; flip = 1'b1;
        end else if (z < -(PI_Q30 / 2)) begin
            z += PI_Q30; flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_N; i++) begin
            at = i < 10 ? cordic_atan(i) : (longint'(1) <<< (30 - i));
            if (z >= 0) begin
                nx = x - floor_sh(y, i); y = y + floor_sh(x, i); z -= at;
            end else begin
                nx = x + floor_sh(y, i); y = y - floor_sh(x, i); z += at;
            end
            x = nx;
        end
        if (flip) begin
            x = -x; y = -y;
        end
        sn = rnd_n(y, 30 - F);
        cs = rnd_n(x, 30 - F);
        ey = rnd_q(128'(-sn) * dx + 128'(cs) * dy);
        if (ey > 128'sd2147483647) ey = 128'sd2147483647;
        if (ey < -128'sd2147483648) ey = -128'sd2147483648;
        e.lateral_error = ey[31:0];
        e.heading_error = 21'(wrap(th - wpsi));
        return e;
    endfunction

    function automatic logic [31:0] rnd_word(input int mode, input logic [31:0] base);
        case (mode)
            0: return $urandom;
            1: return base + $urandom_range(0, 2000) - 1000;
            2: return 32'($signed($urandom_range(0, 8000000)) - 4000000);
            default: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
        endcase
    endfunction

    task automatic push_beat(input logic [31:0] w[9]);
        logic [IN_TDATA_W-1:0] d;
        d = '0;
        for (int i = 0; i < 9; i++) d[i*32 +: 32] = w[i];
        pending_beats.push_back(d);
    endtask

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || s_tready) begin
                if (pending_beats.size() > 0 && !pause_tx &&
                    (calm || $urandom_range(0, 99) >= 14)) begin
                    s_tdata <= pending_beats[0];
                    expected_errs.push_back(project_pose(pending_beats.pop_front()));
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        err_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[52:0];
                if (expected_errs.size() == 0) begin
                    $display("%t unexpected beat actual %h", $realtime, got);
                    errors++;
                end else begin
                    want = expected_errs.pop_front();
                    if (got.lateral_error !== want.lateral_error)
                        $display("%t lateral_error expected %0d actual %0d", $realtime,
                                 want.lateral_error, got.lateral_error);
                    if (got.heading_error !== want.heading_error)
                        $display("%t heading_error expected %0d actual %0d", $realtime,
                                 want.heading_error, got.heading_error);
                    if (got !== want) errors++;
                end
            end
            m_tready <= !hold_rx && (calm || $urandom_range(0, 99) >= 14);
        end
    end

    // receiver hold-off
    initial begin
        wait (start_hold);
        @(posedge aclk);
        hold_rx = 1'b1;
        repeat (200) @(posedge aclk);
        hold_rx = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("frenet_error_projection_unit: mismatch");
        $finish;
    end

    initial begin
        logic [31:0] w[9];
        int mode;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        // extremes, degenerate segment, before start, past end, heading wraps
        for (int k = 0; k < 24; k++) begin
            for (int i = 0; i < 9; i++)
                w[i] = (k < 4) ? ((k[0] ^ i[0]) ? 32'h7fffffff : 32'h80000000)
                               : 32'(i * 262144);
            case (k)
                4: begin w[5] = w[3]; w[6] = w[4]; end
                5: begin w[0] = 32'hfff00000; w[1] = 32'h0; end
                6: begin w[0] = 32'h7f000000; end
                7: begin w[7] = 32'h7fffffff; w[8] = 32'h80000000; end
                8: begin w[2] = 32'h80000000; end
                9: begin w[2] = 32'h7fffffff; end
                10: begin w[5] = w[3] + 1; w[6] = w[4]; end
                11: begin w[0] = 32'h80000000; w[1] = 32'h7fffffff; end
                12: begin w[8] = 32'(823550); w[7] = 32'(-823550); end
                13: begin w[2] = 32'(823551); end
                14: begin w[2] = 32'(-823551); end
                15: for (int i = 0; i < 9; i++) w[i] = 32'h0;
                16: for (int i = 0; i < 9; i++) w[i] = 32'hffffffff;
                default: for (int i = 0; i < 9; i++) w[i] = $urandom;
            endcase
            push_beat(w);
        end
        for (int n = 0; n < 550; n++) begin
            mode = $urandom_range(0, 9);
            for (int i = 0; i < 9; i++)
                w[i] = rnd_word(mode < 2 ? 0 : (mode < 8 ? 2 : 3), 32'h0);
            if (mode == 9) begin
                w[5] = rnd_word(1, w[3]); w[6] = rnd_word(1, w[4]);
            end
            push_beat(w);
            if (n == 150) begin
                while (pending_beats.size() > 20) @(posedge aclk);
                start_hold = 1'b1;
            end
            if (n == 300) begin
                while (pending_beats.size() > 0) @(posedge aclk);
                pause_tx = 1'b1;
                while (expected_errs.size() > 0) @(posedge aclk);
                pause_tx = 1'b0;
                calm = 1'b1;
            end
            if (n == 420) begin
                while (pending_beats.size() > 0) @(posedge aclk);
                calm = 1'b0;
            end
        end
        while (pending_beats.size() > 0 || expected_errs.size() > 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (errors == 0)
            $display("frenet_error_projection_unit: match");
        else
            $display("frenet_error_projection_unit: mismatch");
        $finish;
    end
endmodule

### sim.f
sv/fep_pkg.sv
sv/fep_wrap.sv
sv/fep_div.sv
sv/fep_cordic.sv
sv/frenet_error_projection_unit.sv
tb/sv/tb_frenet_error_projection_unit.sv
